// ===== sv/sbce_pkg.sv =====
// shared types, constants and lookup functions for the serial boot command engine
package sbce_pkg;

  localparam int SBCE_FLASH_ADDR_BITS = 16;
  localparam int SBCE_PAGE_BYTES      = 256;
  localparam int SBCE_KEY_BYTES       = 11;

  localparam logic [15:0] BASE_RESET  = 16'h0800;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;

  localparam logic [7:0] CMD_PROGRAM  = 8'h41;
  localparam logic [7:0] CMD_READ     = 8'hFF;
  localparam logic [7:0] CMD_UNLOCK   = 8'hF5;
  localparam logic [7:0] CMD_STATUS   = 8'h70;
  localparam logic [7:0] CMD_CLEAR    = 8'h50;
  localparam logic [7:0] CMD_BAUD_LO  = 8'hB0;
  localparam logic [7:0] CMD_BAUD_HI  = 8'hB4;
  localparam logic [7:0] CMD_BAUD_9600  = 8'hB0;
  localparam logic [7:0] CMD_BAUD_57600 = 8'hB3;
  localparam logic [7:0] CMD_VERSION  = 8'hFB;

  localparam logic [7:0] STATUS_HEAD     = 8'h80;
  localparam logic [7:0] STATUS_UNLOCKED = 8'h0C;
  localparam logic [7:0] STATUS_LOCKED   = 8'h00;
  localparam logic [7:0] DIV_9600        = 8'd77;
  localparam logic [7:0] DIV_57600       = 8'd12;
  localparam logic [7:0] VERSION_LAST    = 8'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PROG_ADDR,
    PH_PROG_DATA,
    PH_READ_ADDR,
    PH_KEY
  } phase_t;

  typedef enum logic [2:0] {
    RK_NONE,
    RK_ECHO,
    RK_STATUS,
    RK_VERSION,
    RK_PAGE
  } reply_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       baud_change;
    logic [7:0] baud_divisor;
    logic       rx_dropped;
  } out_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_cmd_t;

  typedef struct packed {
    out_t res;
    logic from_mem;
  } stage_t;

  function automatic logic [7:0] key_byte(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'hDF;
      4'd1:    v = 8'hFF;
      4'd2:    v = 8'h00;
      4'd3:    v = 8'h07;
      4'd4:    v = 8'h60;
      4'd5:    v = 8'h00;
      4'd6:    v = 8'h01;
      4'd7:    v = 8'h14;
      4'd8:    v = 8'h46;
      4'd9:    v = 8'h4D;
      4'd10:   v = 8'h52;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h56;
      3'd1:    v = 8'h45;
      3'd2:    v = 8'h52;
      3'd3:    v = 8'h2E;
      3'd4:    v = 8'h31;
      3'd5:    v = 8'h2E;
      3'd6:    v = 8'h30;
      default: v = 8'h30;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/serial_boot_command_engine_top.sv =====
// Serial boot command engine: takes one transaction (received byte or transmit tick) per
// cycle unless stalled and returns exactly one result transaction for each, via the result
// stage (or flash read) register and the output register. The flash store is a single-port
// synchronous memory; program writes and page reads use its one port, one access per
// transaction. After reset an erase pass writes 0xFF, one byte a cycle, to all
// 2^FLASH_ADDR_BITS bytes (65536 by default); in_stall stays high until it ends.
// base_address writes are taken at any time and only move the page pointers on clear-status.
module serial_boot_command_engine_top import sbce_pkg::*; #(
  parameter int FLASH_ADDR_BITS = SBCE_FLASH_ADDR_BITS,
  parameter int PAGE_BYTES      = SBCE_PAGE_BYTES,
  parameter int KEY_BYTES       = SBCE_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  logic                       take;
  logic                       hold;
  logic                       clearing;
  stage_t                     st;
  mem_cmd_t                   mem_cmd;
  logic [FLASH_ADDR_BITS-1:0] mem_addr;
  logic [7:0]                 mem_wdata;
  logic [7:0]                 mem_rdata;

  assign in_stall = rst || clearing || hold;
  assign take     = in_valid && !in_stall;

  sbce_ctrl #(
    .FLASH_ADDR_BITS(FLASH_ADDR_BITS),
    .PAGE_BYTES     (PAGE_BYTES),
    .KEY_BYTES      (KEY_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .take       (take),
    .item       (in_data),
    .st         (st),
    .mem_cmd    (mem_cmd),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata)
  );

  sbce_flash #(
    .FLASH_ADDR_BITS(FLASH_ADDR_BITS)
  ) u_flash (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mem_cmd),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rdata   (mem_rdata),
    .clearing(clearing)
  );

  sbce_out u_out (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .st       (st),
    .rdata    (mem_rdata),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .hold     (hold)
  );

  a_last_needs_tx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.tx_last || out_data.tx_valid))
    else $error("tx_last without tx_valid");

  a_drop_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.rx_dropped && out_data.tx_valid))
    else $error("dropped byte and reply byte in one transaction");

  a_baud_on_echo: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.baud_change) |->
      (out_data.tx_last && (out_data.baud_divisor == DIV_9600 ||
                            out_data.baud_divisor == DIV_57600)))
    else $error("baud change outside a final echo byte");

  a_no_take_in_erase: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !$past(take))
    else $error("transaction accepted during erase pass");

endmodule

// ===== sv/sbce_flash.sv =====
// flash store memory with erase pass after reset
module sbce_flash import sbce_pkg::*; #(
  parameter int FLASH_ADDR_BITS = SBCE_FLASH_ADDR_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mem_cmd_t                   cmd,
  input  logic [FLASH_ADDR_BITS-1:0] addr,
  input  logic [7:0]                 wdata,
  output logic [7:0]                 rdata,
  output logic                       clearing
);

  localparam int DEPTH = 1 << FLASH_ADDR_BITS;

  logic [7:0]               mem [DEPTH];
  logic [FLASH_ADDR_BITS:0] clr_cnt;

  assign clearing = !clr_cnt[FLASH_ADDR_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[FLASH_ADDR_BITS-1:0]] <= ERASED_BYTE;
    end else if (cmd.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/sbce_ctrl.sv =====
// command decoder, protocol phase and page pointers
module sbce_ctrl import sbce_pkg::*; #(
  parameter int FLASH_ADDR_BITS = SBCE_FLASH_ADDR_BITS,
  parameter int PAGE_BYTES      = SBCE_PAGE_BYTES,
  parameter int KEY_BYTES       = SBCE_KEY_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [15:0]                cfg_wr_data,
  input  logic                       take,
  input  in_t                        item,
  output stage_t                     st,
  output mem_cmd_t                   mem_cmd,
  output logic [FLASH_ADDR_BITS-1:0] mem_addr,
  output logic [7:0]                 mem_wdata
);

  localparam int AW = FLASH_ADDR_BITS;
  localparam logic [7:0]    PAGE_LAST = 8'(PAGE_BYTES - 1);
  localparam logic [7:0]    KEY_LAST  = 8'(KEY_BYTES - 1);
  localparam logic [AW-1:0] PAGE_STEP = AW'(PAGE_BYTES);

  logic [15:0]   base_address;
  phase_t        phase, phase_next;
  logic [7:0]    byte_count, byte_count_next;
  logic          key_match, key_match_next;
  logic          key_valid, key_valid_next;
  logic [AW-1:0] write_pointer, write_pointer_next;
  logic [AW-1:0] read_pointer, read_pointer_next;
  reply_t        reply_kind, reply_kind_next;
  logic [7:0]    reply_index, reply_index_next;
  logic [7:0]    echo_byte, echo_byte_next;

  logic [31:0]   base_wide, base_rst_wide;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    b;
  logic          km;

  assign base_wide     = {16'b0, base_address};
  assign base_rst_wide = {16'b0, BASE_RESET};
  assign wr_addr   = write_pointer + AW'(byte_count);
  assign rd_addr   = read_pointer + AW'(reply_index);
  assign b         = item.rx_byte;
  assign mem_wdata = item.rx_byte;
  assign mem_addr  = mem_cmd.rd ? rd_addr : wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
    end else if (cfg_wr_en) begin
      base_address <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_count    <= '0;
      key_match     <= 1'b1;
      key_valid     <= 1'b0;
      write_pointer <= base_rst_wide[AW-1:0];
      read_pointer  <= base_rst_wide[AW-1:0];
      reply_kind    <= RK_NONE;
      reply_index   <= '0;
      echo_byte     <= '0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      key_match     <= key_match_next;
      key_valid     <= key_valid_next;
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      reply_kind    <= reply_kind_next;
      reply_index   <= reply_index_next;
      echo_byte     <= echo_byte_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    key_match_next     = key_match;
    key_valid_next     = key_valid;
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    reply_kind_next    = reply_kind;
    reply_index_next   = reply_index;
    echo_byte_next     = echo_byte;
    st                 = '0;
    mem_cmd            = '0;
    km                 = 1'b0;

    if (take) begin
      if (!item.mode) begin
        if (reply_kind != RK_NONE) begin
          st.res.rx_dropped = 1'b1;
        end else begin
          case (phase)
            PH_PROG_ADDR, PH_READ_ADDR: begin
              if (byte_count == 8'd0) begin
                byte_count_next = 8'd1;
              end else begin
                byte_count_next = '0;
                if (phase == PH_PROG_ADDR) begin
                  phase_next = PH_PROG_DATA;
                end else begin
                  phase_next       = PH_IDLE;
                  reply_kind_next  = RK_PAGE;
                  reply_index_next = '0;
                end
              end
            end
            PH_PROG_DATA: begin
              mem_cmd.wr = 1'b1;
              if (byte_count >= PAGE_LAST) begin
                write_pointer_next = write_pointer + PAGE_STEP;
                byte_count_next    = '0;
                phase_next         = PH_IDLE;
              end else begin
                byte_count_next = byte_count + 8'd1;
              end
            end
            PH_KEY: begin
              km = key_match && (b == key_byte(byte_count[3:0]));
              key_match_next = km;
              if (byte_count >= KEY_LAST) begin
                if (km) begin
                  key_valid_next = 1'b1;
                end
                key_match_next  = 1'b1;
                byte_count_next = '0;
                phase_next      = PH_IDLE;
              end else begin
                byte_count_next = byte_count + 8'd1;
              end
            end
            default: begin
              phase_next      = PH_IDLE;
              byte_count_next = '0;
              if (b inside {[CMD_BAUD_LO:CMD_BAUD_HI]}) begin
                echo_byte_next   = b;
                reply_kind_next  = RK_ECHO;
                reply_index_next = '0;
              end else begin
                case (b)
                  CMD_PROGRAM: phase_next = PH_PROG_ADDR;
                  CMD_READ:    phase_next = PH_READ_ADDR;
                  CMD_CLEAR: begin
                    key_valid_next     = 1'b0;
                    write_pointer_next = base_wide[AW-1:0];
                    read_pointer_next  = base_wide[AW-1:0];
                  end
                  CMD_STATUS: begin
                    reply_kind_next  = RK_STATUS;
                    reply_index_next = '0;
                  end
                  CMD_UNLOCK: begin
                    phase_next     = PH_KEY;
                    key_match_next = 1'b1;
                  end
                  CMD_VERSION: begin
                    reply_kind_next  = RK_VERSION;
                    reply_index_next = '0;
                  end
                  default: ;
                endcase
              end
            end
          endcase
        end
      end else if (reply_kind != RK_NONE) begin
        st.res.tx_valid = 1'b1;
        case (reply_kind)
          RK_ECHO: begin
            st.res.tx_byte = echo_byte;
            st.res.tx_last = 1'b1;
            if (echo_byte == CMD_BAUD_9600) begin
              st.res.baud_change  = 1'b1;
              st.res.baud_divisor = DIV_9600;
            end else if (echo_byte == CMD_BAUD_57600) begin
              st.res.baud_change  = 1'b1;
              st.res.baud_divisor = DIV_57600;
            end
          end
          RK_STATUS: begin
            if (reply_index == 8'd0) begin
              st.res.tx_byte = STATUS_HEAD;
            end else begin
              st.res.tx_byte = key_valid ? STATUS_UNLOCKED : STATUS_LOCKED;
              st.res.tx_last = 1'b1;
            end
          end
          RK_VERSION: begin
            st.res.tx_byte = version_char(reply_index[2:0]);
            st.res.tx_last = (reply_index >= VERSION_LAST);
          end
          default: begin
            mem_cmd.rd  = 1'b1;
            st.from_mem = 1'b1;
            if (reply_index >= PAGE_LAST) begin
              st.res.tx_last    = 1'b1;
              read_pointer_next = read_pointer + PAGE_STEP;
            end
          end
        endcase
        if (st.res.tx_last) begin
          reply_kind_next  = RK_NONE;
          reply_index_next = '0;
        end else begin
          reply_index_next = reply_index + 8'd1;
        end
      end
    end
  end

endmodule

// ===== sv/sbce_out.sv =====
// result stage and output register with flash data merge
module sbce_out import sbce_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  stage_t     st,
  input  logic [7:0] rdata,
  input  logic       out_stall,
  output logic       out_valid,
  output out_t       out_data,
  output logic       hold
);

  logic   mid_valid;
  stage_t mid;
  logic   mid_adv;
  out_t   merged;

  assign mid_adv = !out_valid || !out_stall;
  assign hold    = mid_valid && !mid_adv;

  always_comb begin
    merged = mid.res;
    if (mid.from_mem) begin
      merged.tx_byte = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        mid_valid <= 1'b1;
      end else if (mid_adv) begin
        mid_valid <= 1'b0;
      end
      if (mid_valid && mid_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mid <= st;
    end
    if (mid_valid && mid_adv) begin
      out_data <= merged;
    end
  end

endmodule
